### sv/fir_same_convolution_smoother_defines.svh
// Assertion macros shared by the smoother RTL.
// No dependencies; expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef FIR_SAME_CONVOLUTION_SMOOTHER_DEFINES_SVH
`define FIR_SAME_CONVOLUTION_SMOOTHER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FSCS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FSCS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/fscs_pkg.sv
// Types and constants for the FIR smoother.
// No dependencies; imported by fir_same_convolution_smoother and its bench.
package fscs_pkg;

    // Storage and field widths.
    localparam int MAX_TAPS   = 64;
    localparam int TAP_AW     = 6;
    localparam int SAMPLE_W   = 16;
    localparam int CNT_W      = 13;
    localparam int NTAPS_W    = 7;
    localparam int START_W    = 6;
    localparam int GAIN_W     = 16;
    localparam int ACC_W      = 38;
    localparam int OUT_W      = 38;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Shared multiplier and scaling split.
    localparam int SPLIT   = 19;
    localparam int MUL_A_W = ACC_W - SPLIT + 1;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int LO_W    = SPLIT + GAIN_W;
    localparam int SUM_W   = ACC_W + GAIN_W + 1;
    localparam int FRAC    = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Register reset values.
    localparam logic [NTAPS_W-1:0] NUM_TAPS_RST     = 7'd60;
    localparam logic [START_W-1:0] OUTPUT_START_RST = 6'd29;
    localparam logic [GAIN_W-1:0]  GAIN_RST         = 16'd1092;

    typedef enum logic [1:0] {
        CMD_TAP    = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_DRAIN  = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_TAPS     = 2'd0,
        CFG_OUTPUT_START = 2'd1,
        CFG_GAIN         = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_SCALE_LO,
        S_SCALE_HI,
        S_SUM,
        S_EMIT
    } state_t;

    typedef struct packed {
        cmd_t                       cmd;
        logic [TAP_AW-1:0]          tap_index;
        logic signed [SAMPLE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] filtered;
        logic                    last_output;
    } rsp_t;

endpackage

### sv/fir_same_convolution_smoother.sv
// FIR smoother top level: tap store, circular delay line, shared multiplier and sequencer.
// Depends on fscs_pkg and fir_same_convolution_smoother_defines.svh.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_t: cmd, tap_index, value
//   rsp      out        rsp_valid/rsp_stall  rsp_t: filtered, last_output
//   cfg      in         cfg_we               cfg_index, cfg_data
//
// Tap writes, clears and samples outside the output window leave the sequencer idle.
// A sample or drain inside the window starts the sequencer: the single shared multiplier
// walks the taps one per cycle, then scales the sum in two halves.
// Reset clears the counters, the sequencer and the delay-line fill; taps stay undefined.
// A stalled result holds the sequencer in its last step; req is stalled while busy.
`include "fir_same_convolution_smoother_defines.svh"

module fir_same_convolution_smoother
    import fscs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers.
    logic [NTAPS_W-1:0] num_taps_reg;
    logic [START_W-1:0] output_start_reg;
    logic [GAIN_W-1:0]  gain_reg;

    // Stream state.
    logic [CNT_W-1:0]   position_count_reg;
    logic [CNT_W-1:0]   sample_count_reg;
    logic               window_done_reg;
    logic [TAP_AW-1:0]  wptr_reg;

    // Sequencer and datapath.
    state_t                     state_reg, state_next;
    logic [NTAPS_W-1:0]         taps_reg;
    logic [NTAPS_W-1:0]         issue_cnt_reg;
    logic                       p1_valid_reg, p2_valid_reg, p1_zero_reg;
    logic signed [SAMPLE_W-1:0] tap_rd_reg, dl_rd_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic [LO_W-1:0]            plo_reg;
    logic [OUT_W-1:0]           filt_reg;
    logic                       last_reg;
    logic                       rsp_valid_reg;
    rsp_t                       rsp_reg;

    // Memories.
    logic signed [SAMPLE_W-1:0] tap_mem [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] dl_mem  [MAX_TAPS];

    // Combinational signals.
    logic                       req_accept, tap_we, shift_accept, clear_accept;
    logic [TAP_AW-1:0]          wptr_next;
    logic [CNT_W-1:0]           position_next, sample_next;
    logic [NTAPS_W-1:0]         taps_eff;
    logic [CNT_W-1:0]           taps_ext, span;
    logic [CNT_W:0]             win_lo, win_hi, k_ext;
    logic                       in_win, win_last;
    logic                       issue_en, rsp_free, rsp_load;
    logic [TAP_AW-1:0]          tap_rd_addr, dl_rd_addr;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic [SUM_W-1:0]           sum_full;

    // Input decode.
    assign req_accept = req_valid && !req_stall;
    always_comb
    begin
        tap_we       = 1'b0;
        shift_accept = 1'b0;
        clear_accept = 1'b0;
        unique case (req.cmd)
            CMD_TAP:
            begin
                tap_we = req_accept
                      && ((TAP_AW + 1)'(req.tap_index) < (TAP_AW + 1)'(MAX_TAPS));
            end
            CMD_SAMPLE, CMD_DRAIN:
            begin
                shift_accept = req_accept;
            end
            CMD_CLEAR:
            begin
                clear_accept = req_accept;
            end
        endcase
    end

    // Counter updates and window test for the beat being accepted.
    assign wptr_next     = wptr_reg + 1'b1;
    assign position_next = (position_count_reg == CNT_MAX) ? position_count_reg
                                                           : position_count_reg + 1'b1;
    assign sample_next   = (req.cmd == CMD_SAMPLE && sample_count_reg != CNT_MAX)
                         ? sample_count_reg + 1'b1 : sample_count_reg;

    always_comb
    begin
        if (num_taps_reg == '0)
            taps_eff = NTAPS_W'(1);
        else if (num_taps_reg > NTAPS_W'(MAX_TAPS))
            taps_eff = NTAPS_W'(MAX_TAPS);
        else
            taps_eff = num_taps_reg;
    end

    assign taps_ext = CNT_W'(taps_eff);
    assign span     = (taps_ext > sample_next) ? taps_ext : sample_next;
    assign win_lo   = (CNT_W + 1)'(output_start_reg);
    assign win_hi   = win_lo + (CNT_W + 1)'(span);
    assign k_ext    = (CNT_W + 1)'(position_count_reg);
    assign in_win   = !window_done_reg && (k_ext >= win_lo) && (k_ext < win_hi);
    assign win_last = (k_ext == win_hi - 1'b1);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_taps_reg     <= NUM_TAPS_RST;
            output_start_reg <= OUTPUT_START_RST;
            gain_reg         <= GAIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_TAPS:     num_taps_reg     <= cfg_data[NTAPS_W-1:0];
                CFG_OUTPUT_START: output_start_reg <= cfg_data[START_W-1:0];
                CFG_GAIN:         gain_reg         <= cfg_data[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Stream counters, delay pointer and window flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_count_reg <= '0;
            sample_count_reg   <= '0;
            window_done_reg    <= 1'b0;
            wptr_reg           <= '0;
        end
        else if (clear_accept)
        begin
            position_count_reg <= '0;
            sample_count_reg   <= '0;
            window_done_reg    <= 1'b0;
        end
        else if (shift_accept)
        begin
            position_count_reg <= position_next;
            sample_count_reg   <= sample_next;
            wptr_reg           <= wptr_next;
            if (in_win && win_last)
                window_done_reg <= 1'b1;
        end
    end

    // Tap store: written by tap beats, read one tap a cycle by the MAC walk.
    assign tap_rd_addr = issue_cnt_reg[TAP_AW-1:0];
    always_ff @(posedge clk)
    begin
        if (tap_we)
            tap_mem[req.tap_index] <= req.value;
        tap_rd_reg <= tap_mem[tap_rd_addr];
    end

    // Delay line as a circular buffer; the newest entry sits at wptr_reg.
    assign dl_rd_addr = wptr_reg - issue_cnt_reg[TAP_AW-1:0];
    always_ff @(posedge clk)
    begin
        if (shift_accept)
            dl_mem[wptr_next] <= (req.cmd == CMD_SAMPLE) ? req.value : '0;
        dl_rd_reg <= dl_mem[dl_rd_addr];
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (shift_accept && in_win)
                    state_next = S_MAC;
            end
            S_MAC:
            begin
                if (issue_cnt_reg == taps_reg && !p1_valid_reg && !p2_valid_reg)
                    state_next = S_SCALE_LO;
            end
            S_SCALE_LO: state_next = S_SCALE_HI;
            S_SCALE_HI: state_next = S_SUM;
            S_SUM:      state_next = S_EMIT;
            S_EMIT:
            begin
                if (rsp_free)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and multiplier operand select.
    assign rsp_free = !rsp_valid_reg || !rsp_stall;
    always_comb
    begin
        req_stall = 1'b1;
        issue_en  = 1'b0;
        rsp_load  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
            end
            S_MAC:
            begin
                // Delay entries older than the fill count read as zero.
                issue_en = (issue_cnt_reg < taps_reg);
                mul_a    = p1_zero_reg ? '0 : MUL_A_W'(tap_rd_reg);
                mul_b    = p1_zero_reg ? '0 : MUL_B_W'(dl_rd_reg);
            end
            S_SCALE_LO:
            begin
                mul_a = $signed({1'b0, acc_reg[SPLIT-1:0]});
                mul_b = $signed({1'b0, gain_reg});
            end
            S_SCALE_HI:
            begin
                mul_a = MUL_A_W'($signed(acc_reg[ACC_W-1:SPLIT]));
                mul_b = $signed({1'b0, gain_reg});
            end
            S_SUM:
            begin
            end
            S_EMIT:
            begin
                rsp_load = rsp_free;
            end
            default:
            begin
            end
        endcase
    end

    // The one shared multiplier.
    assign mul_p = mul_a * mul_b;

    // Full product: high half shifted up plus the unsigned low half.
    assign sum_full = (SUM_W'(prod_reg) << SPLIT) + SUM_W'(plo_reg);

    // Sequencer state and MAC pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_cnt_reg <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_valid_reg <= issue_en;
            p2_valid_reg <= p1_valid_reg;
            if (req_accept)
                issue_cnt_reg <= '0;
            else if (issue_en)
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg    <= mul_p;
        p1_zero_reg <= !(CNT_W'(issue_cnt_reg) < position_count_reg);
        if (req_accept)
        begin
            taps_reg <= taps_eff;
            last_reg <= win_last;
            acc_reg  <= '0;
        end
        else if (p2_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (state_reg == S_SCALE_HI)
            plo_reg <= prod_reg[LO_W-1:0];
        if (state_reg == S_SUM)
            filt_reg <= sum_full[FRAC+OUT_W-1:FRAC];
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (rsp_load)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg.filtered    <= $signed(filt_reg);
            rsp_reg.last_output <= last_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks on the sequencer and window bookkeeping.
    `FSCS_ASSERT_IMP(a_issue_bound, state_reg == S_MAC, issue_cnt_reg <= taps_reg,
        "tap walk overran the kernel length")
    `FSCS_ASSERT_IMP(a_mac_drained, state_reg == S_MAC && state_next == S_SCALE_LO,
        !p1_valid_reg && !p2_valid_reg && issue_cnt_reg == taps_reg,
        "scaling began before the MAC pipeline drained")
    `FSCS_ASSERT_IMP(a_idle_empty, state_reg == S_IDLE, !p1_valid_reg && !p2_valid_reg,
        "MAC pipeline busy while idle")
    `FSCS_ASSERT_IMP(a_done_rise, $rose(window_done_reg),
        $past(shift_accept && in_win && win_last),
        "window closed without its last output")

endmodule

### bench/tb_fir_same_convolution_smoother.sv
// Self-checking bench for fir_same_convolution_smoother: random and directed request beats
// are checked against an in-bench predictor of the windowed FIR output.
// Depends on fscs_pkg and the smoother RTL only.
module tb_fir_same_convolution_smoother;
    timeunit 1ns;
    timeprecision 1ps;

    import fscs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int SETTLE = 100;
    localparam int PRINT_CAP = 100;
    localparam int PHASE_BUDGET = 140;
    // Index with no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor state: kernel, delay line, stream counters and register copies.
    logic signed [SAMPLE_W-1:0] coef [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] history [MAX_TAPS];
    logic [CNT_W-1:0] pos_cnt = '0;
    logic [CNT_W-1:0] smp_cnt = '0;
    bit window_closed = 1'b0;
    logic [NTAPS_W-1:0] taps_reg = NUM_TAPS_RST;
    logic [START_W-1:0] start_reg = OUTPUT_START_RST;
    logic [GAIN_W-1:0] gain_reg = GAIN_RST;

    req_t pending [$];
    rsp_t smoothed_due [$];
    int queued = 0;
    int fail_count = 0;
    int unsigned cycles = 0;
    bit req_taken = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int flow_left = 0;

    fir_same_convolution_smoother u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [CNT_W-1:0] count_up_sat(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    // Kernel length actually used: zero acts as one, anything above the store as full.
    function automatic int taps_in_use();
        if (taps_reg == 0)
            return 1;
        if (taps_reg > MAX_TAPS)
            return MAX_TAPS;
        return int'(taps_reg);
    endfunction

    // Applies one request beat to the predictor; returns 1 when it yields a result.
    function automatic bit predict_smoothed(input req_t item, output rsp_t res);
        int i;
        int taps;
        int span;
        int hi;
        int k;
        longint acc;
        longint scaled;
        res = '0;
        if (item.cmd == CMD_TAP)
        begin
            coef[item.tap_index] = item.value;
            return 1'b0;
        end
        if (item.cmd == CMD_CLEAR)
        begin
            for (i = 0; i < MAX_TAPS; i++)
                history[i] = '0;
            pos_cnt = '0;
            smp_cnt = '0;
            window_closed = 1'b0;
            return 1'b0;
        end
        // Sample or drain: shift in the new value (zero for a drain), newest at index 0.
        for (i = MAX_TAPS - 1; i > 0; i--)
            history[i] = history[i-1];
        history[0] = (item.cmd == CMD_SAMPLE) ? item.value : '0;
        if (item.cmd == CMD_SAMPLE)
            smp_cnt = count_up_sat(smp_cnt);
        k = int'(pos_cnt);
        pos_cnt = count_up_sat(pos_cnt);
        taps = taps_in_use();
        acc = 0;
        for (i = 0; i < taps; i++)
            acc += longint'(coef[i]) * longint'(history[i]);
        if (window_closed)
            return 1'b0;
        // The window end follows the current sample count.
        span = (taps > int'(smp_cnt)) ? taps : int'(smp_cnt);
        hi = int'(start_reg) + span;
        if (k < int'(start_reg) || k >= hi)
            return 1'b0;
        scaled = (acc * longint'(gain_reg)) >>> FRAC;
        res.filtered = scaled[OUT_W-1:0];
        res.last_output = (k == hi - 1);
        if (res.last_output)
            window_closed = 1'b1;
        return 1'b1;
    endfunction

    // Every accepted request beat goes through the predictor.
    always @(posedge clk)
    begin : accept_side
        rsp_t due;
        if (rst_n && req_valid && !req_stall)
        begin
            req_taken <= 1'b1;
            if (predict_smoothed(req, due))
                smoothed_due.push_back(due);
        end
        else
        begin
            req_taken <= 1'b0;
        end
    end

    // Request driver: bursts of random length with random gaps, fed from the pending queue.
    always @(negedge clk)
    begin
        if (rst_n && !(req_valid && !req_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (pending.size() > 0)
            begin
                req <= pending.pop_front();
                req_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                             : $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Result stall pattern: free-flowing runs broken by short holds.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else if (flow_left > 0)
        begin
            flow_left--;
            rsp_stall <= 1'b0;
        end
        else
        begin
            flow_left = $urandom_range(0, 30);
            hold_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            rsp_stall <= 1'b0;
        end
    end

    // Monitor: each accepted result beat is checked against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (smoothed_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= PRINT_CAP)
                    $display("%0t: unexpected result, filtered=%0d last_output=%0b",
                             $time, rsp.filtered, rsp.last_output);
            end
            else
            begin
                want = smoothed_due.pop_front();
                if (rsp.filtered !== want.filtered)
                begin
                    fail_count++;
                    if (fail_count <= PRINT_CAP)
                        $display("%0t: filtered expected %0d, got %0d",
                                 $time, want.filtered, rsp.filtered);
                end
                if (rsp.last_output !== want.last_output)
                begin
                    fail_count++;
                    if (fail_count <= PRINT_CAP)
                        $display("%0t: last_output expected %0b, got %0b",
                                 $time, want.last_output, rsp.last_output);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic queue_item(input cmd_t c, input logic [TAP_AW-1:0] idx,
                              input logic [SAMPLE_W-1:0] v);
        req_t it;
        it.cmd = c;
        it.tap_index = idx;
        it.value = v;
        pending.push_back(it);
        queued++;
    endtask

    // Register write while the block is idle; unused data bits carry random junk.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        case (idx)
            CFG_NUM_TAPS:
            begin
                data[NTAPS_W-1:0] = val[NTAPS_W-1:0];
                taps_reg = val[NTAPS_W-1:0];
            end
            CFG_OUTPUT_START:
            begin
                data[START_W-1:0] = val[START_W-1:0];
                start_reg = val[START_W-1:0];
            end
            CFG_GAIN:
            begin
                data = val;
                gain_reg = val;
            end
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every beat is sent and every result is back, then let the block settle.
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (pending.size() != 0 || req_valid || smoothed_due.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // One stream: clear, then samples mixed with drains out to the window end and a bit past.
    task automatic queue_stream(input int n, input bit cut_short);
        int taps;
        int steps;
        int left;
        int s;
        taps = taps_in_use();
        steps = int'(start_reg) + ((taps > n) ? taps : n) + $urandom_range(0, 3);
        if (cut_short)
            steps = $urandom_range(1, steps);
        left = n;
        queue_item(CMD_CLEAR, TAP_AW'($urandom), SAMPLE_W'($urandom));
        for (s = 0; s < steps; s++)
        begin
            if (left > 0 && (s < n / 2 || left >= steps - s || $urandom_range(0, 3) == 0))
            begin
                queue_item(CMD_SAMPLE, TAP_AW'($urandom), pick_value());
                left--;
            end
            else
            begin
                queue_item(CMD_DRAIN, TAP_AW'($urandom), SAMPLE_W'($urandom));
            end
            // Occasionally retune one coefficient in the middle of a stream.
            if ($urandom_range(0, 40) == 0)
                queue_item(CMD_TAP, TAP_AW'($urandom), pick_value());
        end
    endtask

    // Mostly well-formed streams, with stray commands and truncated streams as noise.
    task automatic random_phase(input int budget);
        int goal;
        int n;
        goal = queued + budget;
        while (queued < goal)
        begin
            case ($urandom_range(0, 9))
                0: queue_item(cmd_t'($urandom_range(0, 3)), TAP_AW'($urandom), pick_value());
                1: queue_item(CMD_TAP, TAP_AW'($urandom), pick_value());
                default:
                begin
                    n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 120)
                                                    : $urandom_range(1, taps_in_use() + 8);
                    queue_stream(n, $urandom_range(0, 5) == 0);
                end
            endcase
        end
    endtask

    task automatic config_phase(input logic [CFG_DATA_W-1:0] taps,
                                input logic [CFG_DATA_W-1:0] start,
                                input logic [CFG_DATA_W-1:0] gain, input int budget);
        write_reg(CFG_NUM_TAPS, taps);
        write_reg(CFG_OUTPUT_START, start);
        write_reg(CFG_GAIN, gain);
        random_phase(budget);
        wait_quiet();
    endtask

    initial
    begin : stimulus
        int i;
        for (i = 0; i < MAX_TAPS; i++)
            history[i] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Load the whole kernel first so no unwritten coefficient is ever read.
        for (i = 0; i < MAX_TAPS; i++)
            queue_item(CMD_TAP, TAP_AW'(i), pick_value());
        random_phase(PHASE_BUDGET);
        wait_quiet();

        // Directed: short kernel, window from zero, full-scale gain.
        write_reg(CFG_NUM_TAPS, 16'd4);
        write_reg(CFG_OUTPUT_START, 16'd0);
        write_reg(CFG_GAIN, 16'hFFFF);
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        queue_item(CMD_CLEAR, '0, '0);
        queue_item(CMD_TAP, 6'd0, 16'h8000);
        queue_item(CMD_TAP, 6'd1, 16'h8000);
        queue_item(CMD_TAP, 6'd2, 16'h7FFF);
        queue_item(CMD_TAP, 6'd3, 16'h0000);
        // Extreme samples; the window closes on the fourth one.
        queue_item(CMD_SAMPLE, '1, 16'h8000);
        queue_item(CMD_SAMPLE, '0, 16'h8000);
        queue_item(CMD_SAMPLE, '1, 16'h7FFF);
        queue_item(CMD_SAMPLE, '0, 16'h0000);
        queue_item(CMD_SAMPLE, '1, 16'h0001);
        // Window finished: these shift the line but emit nothing.
        queue_item(CMD_DRAIN, '1, 16'hFFFF);
        queue_item(CMD_SAMPLE, '0, 16'h7FFF);
        // Samples after drains continue the same stream.
        queue_item(CMD_CLEAR, '1, 16'hFFFF);
        queue_item(CMD_SAMPLE, '0, 16'hFFFF);
        queue_item(CMD_DRAIN, '0, 16'h0000);
        queue_item(CMD_DRAIN, '1, 16'h5555);
        queue_item(CMD_SAMPLE, '1, 16'h3039);
        queue_item(CMD_DRAIN, '0, 16'hAAAA);
        // Drains alone still produce a kernel-length window.
        queue_item(CMD_CLEAR, '0, '0);
        queue_item(CMD_DRAIN, '0, '0);
        queue_item(CMD_DRAIN, '1, '1);
        queue_item(CMD_DRAIN, '0, '0);
        queue_item(CMD_DRAIN, '1, '1);
        queue_item(CMD_TAP, 6'd63, 16'h7FFF);
        wait_quiet();

        // Register extremes, out-of-range kernel lengths, then random settings.
        config_phase(16'd64, 16'd63, 16'hFFFF, PHASE_BUDGET);
        config_phase(16'd1, 16'd0, 16'd0, PHASE_BUDGET);
        config_phase(16'd0, 16'd5, 16'h8000, PHASE_BUDGET);
        config_phase(16'd127, 16'd10, 16'd1, PHASE_BUDGET);
        for (i = 0; i < 3; i++)
            config_phase(CFG_DATA_W'($urandom_range(1, MAX_TAPS)),
                         CFG_DATA_W'($urandom_range(0, 63)),
                         CFG_DATA_W'($urandom), PHASE_BUDGET);

        @(negedge clk);
        if (fail_count == 0 && smoothed_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
